### design/dcf_pkg.sv
package dcf_pkg;

  // Tick counter width of all measured lengths and window bounds
  localparam int TICK_WIDTH = 16;

  // Register file
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = 5;
  localparam int APB_W     = 32;

  typedef logic [TICK_WIDTH-1:0] tick_t;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_SEC_MIN    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SEC_MAX    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ZERO_MIN   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ZERO_MAX   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ONE_MIN    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ONE_MAX    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MARKER_MIN = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_MARKER_MAX = 3'd7;

  // Reset values, in register order
  localparam tick_t REG_RESET [NUM_REGS] = '{
    tick_t'(16'h3800), tick_t'(16'h4000), tick_t'(16'h0300), tick_t'(16'h0680),
    tick_t'(16'h0900), tick_t'(16'h0D00), tick_t'(16'h7000), tick_t'(16'h9000)
  };

  // Window bounds as seen by the classifier
  typedef struct packed {
    tick_t sec_min;
    tick_t sec_max;
    tick_t zero_min;
    tick_t zero_max;
    tick_t one_min;
    tick_t one_max;
    tick_t marker_min;
    tick_t marker_max;
  } cfg_t;

  // Second slots of the time fields within a frame
  localparam int SEC_W = 6;
  localparam logic [SEC_W-1:0] MIN_FIRST  = 6'd21;
  localparam logic [SEC_W-1:0] MIN_END    = 6'd28;
  localparam logic [SEC_W-1:0] HOUR_FIRST = 6'd29;
  localparam logic [SEC_W-1:0] HOUR_END   = 6'd35;
  localparam logic [SEC_W-1:0] DAY_FIRST  = 6'd36;
  localparam logic [SEC_W-1:0] DAY_END    = 6'd42;
  localparam logic [SEC_W-1:0] SEC_LAST   = 6'd63;

  localparam int MINUTE_W = 7;
  localparam int HOUR_W   = 6;
  localparam int DAY_W    = 6;
  localparam int COUNT_W  = 16;
  localparam int IN_W     = 2 * TICK_WIDTH;
  localparam int OUT_W    = 40;

  // Class of one measured second
  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_MARKER,
    KIND_OTHER
  } kind_t;

  // Queue entry from classifier to frame engine
  typedef struct packed {
    kind_t kind;
    logic  bit_val;
    logic  bad_pulse;
  } sec_item_t;

  // Exclusive window test
  function automatic logic in_window(tick_t v, tick_t lo, tick_t hi);
    return (v > lo) && (v < hi);
  endfunction

endpackage

### design/dcf77_time_frame_decoder_unit.sv
// DCF77 time frame decoder. Each input transfer is one measured second
// (period and high-pulse length in timer ticks); a result transfer comes out
// only on a minute marker and carries the decoded minute, hour and day in BCD,
// frame_ok in tuser, and the running count of rejected frames. The block takes
// one second per clock cycle, except while a marker waits on a stalled result
// side; a result passes through the front stage register, the two-entry queue
// and the output register of the frame engine, in that order.
// After reset the first frame is rejected because it starts partway through.
// Program the eight window bounds over the register port only while idle.
module dcf77_time_frame_decoder_unit (
  input  logic                        clk,
  input  logic                        rst,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dcf_pkg::ADDR_W-1:0]  paddr,
  input  logic [dcf_pkg::APB_W-1:0]   pwdata,
  output logic [dcf_pkg::APB_W-1:0]   prdata,
  output logic                        pready,
  // measured seconds
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [dcf_pkg::IN_W-1:0]    s_tdata,   // period_len, high_len
  // decoded frames
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [dcf_pkg::OUT_W-1:0]   m_tdata,   // minute_bcd, hour_bcd, day_bcd,
                                                 // bad_frame_count, zero pad
  output logic                        m_tuser    // frame_ok
);

  dcf_pkg::tick_t                cfg_regs [dcf_pkg::NUM_REGS];
  logic [dcf_pkg::REG_IDX_W-1:0] reg_idx;
  dcf_pkg::cfg_t                 cfg;
  logic                          fq_valid;
  logic                          fq_ready;
  dcf_pkg::sec_item_t            fq_item;
  logic                          qb_valid;
  logic                          qb_ready;
  dcf_pkg::sec_item_t            qb_item;

  assign pready  = 1'b1;
  assign reg_idx = paddr[dcf_pkg::ADDR_W-1:2];
  assign prdata  = {{(dcf_pkg::APB_W-dcf_pkg::TICK_WIDTH){1'b0}}, cfg_regs[reg_idx]};

  // Write window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dcf_pkg::NUM_REGS; i++) begin
        cfg_regs[i] <= dcf_pkg::REG_RESET[i];
      end
    end else if (psel && penable && pwrite && pready) begin
      cfg_regs[reg_idx] <= pwdata[dcf_pkg::TICK_WIDTH-1:0];
    end
  end

  assign cfg.sec_min    = cfg_regs[dcf_pkg::REG_SEC_MIN];
  assign cfg.sec_max    = cfg_regs[dcf_pkg::REG_SEC_MAX];
  assign cfg.zero_min   = cfg_regs[dcf_pkg::REG_ZERO_MIN];
  assign cfg.zero_max   = cfg_regs[dcf_pkg::REG_ZERO_MAX];
  assign cfg.one_min    = cfg_regs[dcf_pkg::REG_ONE_MIN];
  assign cfg.one_max    = cfg_regs[dcf_pkg::REG_ONE_MAX];
  assign cfg.marker_min = cfg_regs[dcf_pkg::REG_MARKER_MIN];
  assign cfg.marker_max = cfg_regs[dcf_pkg::REG_MARKER_MAX];

  dcf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_item   (fq_item)
  );

  dcf_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_item  (qb_item)
  );

  dcf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (qb_valid),
    .q_ready  (qb_ready),
    .q_item   (qb_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### design/dcf_front.sv
module dcf_front (
  input  logic                    clk,
  input  logic                    rst,
  input  dcf_pkg::cfg_t           cfg,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [dcf_pkg::IN_W-1:0] s_tdata,  // period_len, high_len
  output logic                    q_valid,
  input  logic                    q_ready,
  output dcf_pkg::sec_item_t      q_item
);

  dcf_pkg::tick_t     period_len;
  dcf_pkg::tick_t     high_len;
  logic               is_data;
  logic               is_marker;
  logic               is_zero;
  logic               is_one;
  dcf_pkg::sec_item_t item_next;
  logic               stage_valid;
  dcf_pkg::sec_item_t stage_item;

  assign period_len = s_tdata[dcf_pkg::TICK_WIDTH-1:0];
  assign high_len   = s_tdata[dcf_pkg::IN_W-1:dcf_pkg::TICK_WIDTH];

  // Classify period and pulse length against the windows
  always_comb begin
    is_data   = dcf_pkg::in_window(period_len, cfg.sec_min, cfg.sec_max);
    is_marker = dcf_pkg::in_window(period_len, cfg.marker_min, cfg.marker_max);
    is_zero   = dcf_pkg::in_window(high_len, cfg.zero_min, cfg.zero_max);
    is_one    = dcf_pkg::in_window(high_len, cfg.one_min, cfg.one_max);
    item_next.bit_val   = !is_zero && is_one;
    item_next.bad_pulse = !is_zero && !is_one;
    if (is_data) begin
      item_next.kind = dcf_pkg::KIND_DATA;
    end else if (is_marker) begin
      item_next.kind = dcf_pkg::KIND_MARKER;
    end else begin
      item_next.kind = dcf_pkg::KIND_OTHER;
    end
  end

  assign s_tready = !stage_valid || q_ready;

  // Hold classified second until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tready) begin
      stage_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      stage_item <= item_next;
    end
  end

  assign q_valid = stage_valid;
  assign q_item  = stage_item;

endmodule

### design/dcf_fifo.sv
module dcf_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  dcf_pkg::sec_item_t wr_item,
  output logic               rd_valid,
  input  logic               rd_ready,
  output dcf_pkg::sec_item_t rd_item
);

  dcf_pkg::sec_item_t entries [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               push;
  logic               pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

endmodule

### design/dcf_back.sv
module dcf_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  dcf_pkg::sec_item_t        q_item,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [dcf_pkg::OUT_W-1:0] m_tdata,  // minute_bcd, hour_bcd, day_bcd,
                                              // bad_frame_count, zero pad
  output logic                      m_tuser   // frame_ok
);

  logic [dcf_pkg::SEC_W-1:0]    second_index;
  logic [dcf_pkg::MINUTE_W-1:0] minute_shift;
  logic [dcf_pkg::HOUR_W-1:0]   hour_shift;
  logic [dcf_pkg::DAY_W-1:0]    day_shift;
  logic                         frame_poisoned;
  logic [dcf_pkg::COUNT_W-1:0]  bad_frames;
  logic [dcf_pkg::COUNT_W-1:0]  bad_frames_next;
  logic                         out_free;
  logic                         take;
  logic                         shift_bit;
  logic                         frame_ok;

  assign out_free  = !m_tvalid || m_tready;
  assign q_ready   = (q_item.kind != dcf_pkg::KIND_MARKER) || out_free;
  assign take      = q_valid && q_ready;
  assign shift_bit = q_item.bit_val && !q_item.bad_pulse;
  assign frame_ok  = !frame_poisoned;
  assign bad_frames_next = bad_frames + {{(dcf_pkg::COUNT_W-1){1'b0}}, frame_poisoned};

  // Update frame state per second
  always_ff @(posedge clk) begin
    if (rst) begin
      second_index   <= '0;
      minute_shift   <= '0;
      hour_shift     <= '0;
      day_shift      <= '0;
      frame_poisoned <= 1'b1;
      bad_frames     <= '0;
    end else if (take) begin
      case (q_item.kind)
        dcf_pkg::KIND_DATA: begin
          if (q_item.bad_pulse) begin
            frame_poisoned <= 1'b1;
          end
          if (second_index >= dcf_pkg::MIN_FIRST && second_index < dcf_pkg::MIN_END) begin
            minute_shift <= {shift_bit, minute_shift[dcf_pkg::MINUTE_W-1:1]};
          end else if (second_index >= dcf_pkg::HOUR_FIRST &&
                       second_index < dcf_pkg::HOUR_END) begin
            hour_shift <= {shift_bit, hour_shift[dcf_pkg::HOUR_W-1:1]};
          end else if (second_index >= dcf_pkg::DAY_FIRST &&
                       second_index < dcf_pkg::DAY_END) begin
            day_shift <= {shift_bit, day_shift[dcf_pkg::DAY_W-1:1]};
          end
          if (second_index != dcf_pkg::SEC_LAST) begin
            second_index <= second_index + dcf_pkg::SEC_W'(1);
          end
        end
        dcf_pkg::KIND_MARKER: begin
          bad_frames     <= bad_frames_next;
          frame_poisoned <= 1'b0;
          second_index   <= '0;
          minute_shift   <= '0;
          hour_shift     <= '0;
          day_shift      <= '0;
        end
        default: begin
          frame_poisoned <= 1'b1;
        end
      endcase
    end
  end

  // Output register: load a result on the minute marker
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= take && (q_item.kind == dcf_pkg::KIND_MARKER);
    end
    if (take && q_item.kind == dcf_pkg::KIND_MARKER) begin
      m_tdata <= {5'b0, bad_frames_next,
                  frame_ok ? day_shift : {dcf_pkg::DAY_W{1'b0}},
                  frame_ok ? hour_shift : {dcf_pkg::HOUR_W{1'b0}},
                  frame_ok ? minute_shift : {dcf_pkg::MINUTE_W{1'b0}}};
      m_tuser <= frame_ok;
    end
  end

endmodule

### design/dcf_checker.sv
module dcf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [dcf_pkg::ADDR_W-1:0] paddr,
  input logic [dcf_pkg::APB_W-1:0]  pwdata,
  input logic [dcf_pkg::APB_W-1:0]  prdata,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [dcf_pkg::OUT_W-1:0]  m_tdata,
  input logic                       m_tuser
);

  // Result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Rejected frame carries no time
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[18:0] == 19'd0)
    else $error("rejected frame shows time fields");

  // Reset empties the output
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Register reads back what was written
  a_readback: assert property (@(posedge clk) disable iff (rst)
    $past(psel && penable && pwrite) && !$past(rst) && psel && !pwrite &&
    paddr == $past(paddr) |->
    prdata == {16'd0, $past(pwdata[15:0])})
    else $error("register readback mismatch");

endmodule

bind dcf77_time_frame_decoder_unit dcf_checker u_dcf_checker (
  .clk      (clk),
  .rst      (rst),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;

  // Predicts decoded frames from accepted seconds and checks result transfers
  class frame_scoreboard;
    typedef struct {
      logic [dcf_pkg::MINUTE_W-1:0] minute;
      logic [dcf_pkg::HOUR_W-1:0]   hour;
      logic [dcf_pkg::DAY_W-1:0]    day;
      logic                         ok;
      logic [dcf_pkg::COUNT_W-1:0]  bad_count;
    } frame_t;

    dcf_pkg::tick_t               win [dcf_pkg::NUM_REGS];
    logic [dcf_pkg::SEC_W-1:0]    sec_idx;
    logic [dcf_pkg::MINUTE_W-1:0] minute_sr;
    logic [dcf_pkg::HOUR_W-1:0]   hour_sr;
    logic [dcf_pkg::DAY_W-1:0]    day_sr;
    logic                         poisoned;
    logic [dcf_pkg::COUNT_W-1:0]  bad_frames;
    frame_t                       pending [$];
    int                           seconds_taken;
    int                           errors;

    function new();
      foreach (win[i]) win[i] = dcf_pkg::REG_RESET[i];
      sec_idx = '0;
      minute_sr = '0;
      hour_sr = '0;
      day_sr = '0;
      poisoned = 1'b1;
      bad_frames = '0;
      seconds_taken = 0;
      errors = 0;
    endfunction

    function void set_window(int idx, logic [dcf_pkg::APB_W-1:0] val);
      if (idx < dcf_pkg::NUM_REGS) win[idx] = val[dcf_pkg::TICK_WIDTH-1:0];
    endfunction

    static function bit strictly_between(dcf_pkg::tick_t v, dcf_pkg::tick_t lo,
                                         dcf_pkg::tick_t hi);
      return (v > lo) && (v < hi);
    endfunction

    // Advance the frame state by one measured second
    function void take_second(dcf_pkg::tick_t period, dcf_pkg::tick_t high);
      logic   pulse;
      frame_t fr;
      seconds_taken++;
      if (strictly_between(period, win[dcf_pkg::REG_SEC_MIN], win[dcf_pkg::REG_SEC_MAX])) begin
        pulse = 1'b0;
        if (strictly_between(high, win[dcf_pkg::REG_ZERO_MIN],
                             win[dcf_pkg::REG_ZERO_MAX])) begin
          pulse = 1'b0;
        end else if (strictly_between(high, win[dcf_pkg::REG_ONE_MIN],
                                      win[dcf_pkg::REG_ONE_MAX])) begin
          pulse = 1'b1;
        end else begin
          poisoned = 1'b1;
        end
        if (sec_idx >= dcf_pkg::MIN_FIRST && sec_idx < dcf_pkg::MIN_END) begin
          minute_sr = {pulse, minute_sr[dcf_pkg::MINUTE_W-1:1]};
        end else if (sec_idx >= dcf_pkg::HOUR_FIRST && sec_idx < dcf_pkg::HOUR_END) begin
          hour_sr = {pulse, hour_sr[dcf_pkg::HOUR_W-1:1]};
        end else if (sec_idx >= dcf_pkg::DAY_FIRST && sec_idx < dcf_pkg::DAY_END) begin
          day_sr = {pulse, day_sr[dcf_pkg::DAY_W-1:1]};
        end
        if (sec_idx != dcf_pkg::SEC_LAST) sec_idx++;
      end else if (strictly_between(period, win[dcf_pkg::REG_MARKER_MIN],
                                    win[dcf_pkg::REG_MARKER_MAX])) begin
        // Close the frame: rejected frames report zero time fields
        if (poisoned) bad_frames++;
        fr.ok = !poisoned;
        fr.minute = poisoned ? '0 : minute_sr;
        fr.hour = poisoned ? '0 : hour_sr;
        fr.day = poisoned ? '0 : day_sr;
        fr.bad_count = bad_frames;
        pending.push_back(fr);
        poisoned = 1'b0;
        sec_idx = '0;
        minute_sr = '0;
        hour_sr = '0;
        day_sr = '0;
      end else begin
        poisoned = 1'b1;
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one result transfer against the oldest predicted frame
    function void check_frame(logic [dcf_pkg::OUT_W-1:0] data, logic flag);
      frame_t fr;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                 $time, data, flag);
        errors++;
        return;
      end
      fr = pending.pop_front();
      compare_field("minute_bcd", fr.minute, data[dcf_pkg::MINUTE_W-1:0]);
      compare_field("hour_bcd", fr.hour, data[dcf_pkg::MINUTE_W +: dcf_pkg::HOUR_W]);
      compare_field("day_bcd", fr.day,
                    data[dcf_pkg::MINUTE_W+dcf_pkg::HOUR_W +: dcf_pkg::DAY_W]);
      compare_field("bad_frame_count", fr.bad_count,
                    data[dcf_pkg::MINUTE_W+dcf_pkg::HOUR_W+dcf_pkg::DAY_W +: dcf_pkg::COUNT_W]);
      compare_field("frame_ok", fr.ok, flag);
    endfunction

    function void report_leftover();
      if (pending.size() != 0) begin
        $display("%0t: %0d frames expected, actual none arrived", $time, pending.size());
        errors++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [dcf_pkg::ADDR_W-1:0] paddr = '0;
  logic [dcf_pkg::APB_W-1:0]  pwdata = '0;
  logic [dcf_pkg::APB_W-1:0]  prdata;
  logic                       pready;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [dcf_pkg::IN_W-1:0]   s_tdata = '0;   // period_len, high_len
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [dcf_pkg::OUT_W-1:0]  m_tdata;  // minute_bcd, hour_bcd, day_bcd, bad_frame_count, pad
  logic                       m_tuser;  // frame_ok

  frame_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  dcf77_time_frame_decoder_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Note accepted seconds and check result transfers
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.take_second(s_tdata[dcf_pkg::TICK_WIDTH-1:0],
                     s_tdata[dcf_pkg::TICK_WIDTH +: dcf_pkg::TICK_WIDTH]);
    if (!rst && m_tvalid && m_tready) sb.check_frame(m_tdata, m_tuser);
  end

  // Stall the result side at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Abort when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no transfer in %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic write_window(logic [dcf_pkg::REG_IDX_W-1:0] idx, dcf_pkg::tick_t val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {(dcf_pkg::APB_W-dcf_pkg::TICK_WIDTH)'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_window(idx, {{(dcf_pkg::APB_W-dcf_pkg::TICK_WIDTH){1'b0}}, val});
  endtask

  task automatic set_windows(dcf_pkg::tick_t sec_lo, dcf_pkg::tick_t sec_hi,
                             dcf_pkg::tick_t zero_lo, dcf_pkg::tick_t zero_hi,
                             dcf_pkg::tick_t one_lo, dcf_pkg::tick_t one_hi,
                             dcf_pkg::tick_t mark_lo, dcf_pkg::tick_t mark_hi);
    write_window(dcf_pkg::REG_SEC_MIN, sec_lo);
    write_window(dcf_pkg::REG_SEC_MAX, sec_hi);
    write_window(dcf_pkg::REG_ZERO_MIN, zero_lo);
    write_window(dcf_pkg::REG_ZERO_MAX, zero_hi);
    write_window(dcf_pkg::REG_ONE_MIN, one_lo);
    write_window(dcf_pkg::REG_ONE_MAX, one_hi);
    write_window(dcf_pkg::REG_MARKER_MIN, mark_lo);
    write_window(dcf_pkg::REG_MARKER_MAX, mark_hi);
  endtask

  // Send one second, with random idle cycles ahead of it
  task automatic send_second(dcf_pkg::tick_t period, dcf_pkg::tick_t high);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct && gap < 40) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      gap++;
    end
    s_tvalid <= 1'b1;
    s_tdata <= {high, period};
    do @(posedge clk); while (!s_tready);
  endtask

  // Hold the sender until all frames are out and the pipeline is empty
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic dcf_pkg::tick_t pick_in(dcf_pkg::tick_t lo, dcf_pkg::tick_t hi);
    if (hi > lo + 1) return dcf_pkg::tick_t'($urandom_range(lo + 1, hi - 1));
    return dcf_pkg::tick_t'($urandom());
  endfunction

  function automatic dcf_pkg::tick_t data_pulse();
    if ($urandom_range(1))
      return pick_in(sb.win[dcf_pkg::REG_ONE_MIN], sb.win[dcf_pkg::REG_ONE_MAX]);
    return pick_in(sb.win[dcf_pkg::REG_ZERO_MIN], sb.win[dcf_pkg::REG_ZERO_MAX]);
  endfunction

  // One frame: data seconds, then a marker; some frames carry noise or lack the marker
  task automatic send_frame();
    int  n;
    int  r;
    int  i;
    bit  clean;
    r = $urandom_range(99);
    if (r < 45) n = $urandom_range(43, 59);
    else if (r < 75) n = $urandom_range(0, 42);
    else if (r < 90) n = $urandom_range(60, 72);
    else n = $urandom_range(15, 30);
    clean = ($urandom_range(99) < 80);
    for (i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (!clean && r < 6)
        send_second(dcf_pkg::tick_t'($urandom()), dcf_pkg::tick_t'($urandom()));
      else if (!clean && r < 10)
        send_second(pick_in(sb.win[dcf_pkg::REG_SEC_MIN], sb.win[dcf_pkg::REG_SEC_MAX]),
                    dcf_pkg::tick_t'($urandom()));
      send_second(pick_in(sb.win[dcf_pkg::REG_SEC_MIN], sb.win[dcf_pkg::REG_SEC_MAX]),
                  data_pulse());
    end
    if (clean || $urandom_range(99) < 70)
      send_second(pick_in(sb.win[dcf_pkg::REG_MARKER_MIN], sb.win[dcf_pkg::REG_MARKER_MAX]),
                  dcf_pkg::tick_t'($urandom()));
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed seconds at reset bounds; the first frame is partial and rejected
    send_second(16'h3801, 16'h0301);
    send_second(16'h3FFF, 16'h0CFF);
    send_second(16'h3800, 16'h0400);
    send_second(16'h4000, 16'h0400);
    send_second(16'h0000, 16'h0000);
    send_second(16'hFFFF, 16'hFFFF);
    send_second(16'h7001, 16'h0000);
    send_second(16'h3900, 16'h0500);
    send_second(16'h3900, 16'h0A00);
    send_second(16'h8FFF, 16'hFFFF);
    send_second(16'h3900, 16'h0300);
    send_second(16'h3900, 16'h0680);
    send_second(16'h3900, 16'h0900);
    send_second(16'h3900, 16'h0D00);
    send_second(16'h3900, 16'h0000);
    send_second(16'h3900, 16'hFFFF);
    send_second(16'h7000, 16'h0400);
    send_second(16'h9000, 16'h0400);
    send_second(16'h8000, 16'h0400);
    send_second(16'h8000, 16'h0400);

    // Reset bounds, no idling
    while (sb.seconds_taken < 300) send_frame();
    settle();

    // Overlapping windows, sender idles; pause once until all frames are out
    set_windows(16'h3000, 16'h4800, 16'h0200, 16'h0800,
                16'h0600, 16'h0E00, 16'h4000, 16'h9000);
    send_idle_pct = 73;
    while (sb.seconds_taken < 450) send_frame();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    while (sb.seconds_taken < 600) send_frame();
    settle();

    // Extreme bounds: wide windows, an empty one-window, marker at period one
    set_windows(16'h0001, 16'hFFFF, 16'h0000, 16'hFFFF,
                16'hFFFF, 16'h0000, 16'h0000, 16'h0002);
    send_idle_pct = 0;
    recv_stall_pct = 73;
    while (sb.seconds_taken < 750) send_frame();
    settle();

    // All windows empty: every second poisons, no frames come out
    set_windows('0, '0, '0, '0, '0, '0, '0, '0);
    while (sb.seconds_taken < 790) send_frame();
    settle();

    // Back to the usual bounds, both sides idling
    set_windows(16'h3800, 16'h4000, 16'h0300, 16'h0680,
                16'h0900, 16'h0D00, 16'h7000, 16'h9000);
    send_idle_pct = 23;
    recv_stall_pct = 23;
    while (sb.seconds_taken < 1100) send_frame();
    settle();

    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
